@@ hdl/mbe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants of the escape-time pixel block.
// ----------------------------------------------------------------------------
package mbe_pkg;

	localparam int CNT_W      = 10;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int START_FRAC = 28;
	localparam int SCALE_W    = 18;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_RE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_IM     = 3'd4;

	localparam int RST_IMAGE_DIM = 1000;
	localparam logic [CNT_W-1:0] RST_MAX_ITERS = 10'd75;

	localparam int RED_SCALE   = 100;
	localparam int GREEN_SCALE = 195;
	localparam int BLUE_SCALE  = 220;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_DIV,
		FR_PUSH
	} fr_state_t;

	typedef enum logic [2:0] {
		IT_IDLE,
		IT_MUL,
		IT_SUM,
		IT_TEST,
		IT_UPD,
		IT_DONE
	} it_state_t;

	typedef enum logic [1:0] {
		CL_IDLE,
		CL_DIV,
		CL_FULL
	} cl_state_t;

	typedef struct packed {
		logic             valid;
		logic [CNT_W-1:0] count;
	} mbe_cnt_t;

endpackage

@@ hdl/mbe_pix_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pix_if
// Pixel position channel.
// ----------------------------------------------------------------------------
interface mbe_pix_if #(
	parameter int DIM_BITS = 12
) ();
	logic                valid;
	logic                ready;
	logic [DIM_BITS-1:0] pixel_x;
	logic [DIM_BITS-1:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

@@ hdl/mbe_res_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_res_if
// Result channel: iteration count and colour.
// ----------------------------------------------------------------------------
interface mbe_res_if ();
	logic       valid;
	logic       ready;
	logic [9:0] iter_count;
	logic [6:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output iter_count, output red, output green,
		output blue, input ready);
	modport sink (input valid, input iter_count, input red, input green,
		input blue, output ready);
endinterface

@@ hdl/mbe_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_front
// Takes a pixel request and maps both coordinates to fixed point with two
// bit-serial restoring dividers.
// ----------------------------------------------------------------------------
module mbe_front #(
	parameter int FRAC_BITS = 28,
	parameter int DIM_BITS  = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	mbe_pix_if.sink                      pix,
	input  logic [DIM_BITS:0]            dim_w,
	input  logic [DIM_BITS:0]            dim_h,
	output logic                         push_valid,
	input  logic                         push_ready,
	output logic [2*(FRAC_BITS+4)-1:0]   push_data
);
	localparam int W  = FRAC_BITS + 4;
	localparam int DW = DIM_BITS + 1;
	localparam int MW = DIM_BITS + 2;
	localparam int NB = MW + FRAC_BITS;
	localparam int XW = NB + 2;
	localparam int CW = $clog2(NB + 1);

	localparam logic signed [XW-1:0] WMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [XW-1:0] WMIN_X = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic signed [XW-1:0] HALF_X = {{(XW-FRAC_BITS){1'b0}}, 1'b1,
		{(FRAC_BITS-1){1'b0}}};

	mbe_pkg::fr_state_t fr_q, fr_nx;
	logic [CW-1:0]      step_q;

	logic [DW-1:0] dsor_q [2];
	logic [NB-1:0] num_q  [2];
	logic [DW-1:0] rem_q  [2];
	logic          neg_q  [2];

	logic [DIM_BITS-1:0]     pix_l  [2];
	logic [DW-1:0]           dim_l  [2];
	logic [DW-1:0]           d_l    [2];
	logic signed [DIM_BITS:0] diff_l [2];
	logic [MW-1:0]           n_l    [2];
	logic [MW-1:0]           mag_l  [2];
	logic [DW:0]             rem_sh [2];
	logic                    ge     [2];
	logic [DW-1:0]           rem_nx [2];
	logic signed [XW-1:0]    qv     [2];
	logic signed [XW-1:0]    qf     [2];
	logic signed [XW-1:0]    fix    [2];
	logic [W-1:0]            coord  [2];

	always_comb begin
		pix_l[0] = pix.pixel_x;
		pix_l[1] = pix.pixel_y;
		dim_l[0] = dim_w;
		dim_l[1] = dim_h;
		for (int i = 0; i < 2; i++) begin
			d_l[i]    = (dim_l[i] == '0) ? DW'(1) : dim_l[i];
			diff_l[i] = $signed({1'b0, pix_l[i]}) - $signed({1'b0, d_l[i][DW-1:1]});
			n_l[i]    = {diff_l[i], 1'b0};
			mag_l[i]  = n_l[i][MW-1] ? MW'(-n_l[i]) : n_l[i];
			rem_sh[i] = {rem_q[i], num_q[i][NB-1]};
			ge[i]     = rem_sh[i] >= {1'b0, dsor_q[i]};
			rem_nx[i] = ge[i] ? DW'(rem_sh[i] - {1'b0, dsor_q[i]}) : rem_sh[i][DW-1:0];
			// floor of the signed quotient, then the half offset on the real axis
			qv[i] = $signed({2'b00, num_q[i]});
			qf[i] = neg_q[i] ? -(qv[i] + $signed({{(XW-1){1'b0}}, rem_q[i] != '0}))
				: qv[i];
			fix[i] = (i == 0) ? qf[i] - HALF_X : qf[i];
			if (fix[i] > WMAX_X)
				coord[i] = WMAX_X[W-1:0];
			else if (fix[i] < WMIN_X)
				coord[i] = WMIN_X[W-1:0];
			else
				coord[i] = fix[i][W-1:0];
		end
	end

	always_comb begin
		fr_nx = fr_q;
		unique case (fr_q)
			mbe_pkg::FR_IDLE: begin
				if (pix.valid)
					fr_nx = mbe_pkg::FR_DIV;
			end
			mbe_pkg::FR_DIV: begin
				if (step_q == CW'(NB - 1))
					fr_nx = mbe_pkg::FR_PUSH;
			end
			mbe_pkg::FR_PUSH: begin
				if (push_ready)
					fr_nx = mbe_pkg::FR_IDLE;
			end
			default: fr_nx = mbe_pkg::FR_IDLE;
		endcase
	end

	always_comb begin
		pix.ready  = (fr_q == mbe_pkg::FR_IDLE);
		push_valid = (fr_q == mbe_pkg::FR_PUSH);
		push_data  = {coord[0], coord[1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_q   <= mbe_pkg::FR_IDLE;
			step_q <= '0;
		end else begin
			fr_q <= fr_nx;
			if (fr_q == mbe_pkg::FR_DIV)
				step_q <= step_q + CW'(1);
			else
				step_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			if (fr_q == mbe_pkg::FR_IDLE && pix.valid) begin
				dsor_q[i] <= d_l[i];
				num_q[i]  <= {mag_l[i], {FRAC_BITS{1'b0}}};
				rem_q[i]  <= '0;
				neg_q[i]  <= n_l[i][MW-1];
			end else if (fr_q == mbe_pkg::FR_DIV) begin
				num_q[i] <= {num_q[i][NB-2:0], ge[i]};
				rem_q[i] <= rem_nx[i];
			end
		end
	end

endmodule

@@ hdl/mbe_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_fifo
// Two-entry queue between coordinate front and iteration core.
// ----------------------------------------------------------------------------
module mbe_fifo #(
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  logic [DATA_W-1:0] wr_data,
	output logic              rd_valid,
	input  logic              rd_pop,
	output logic [DATA_W-1:0] rd_data
);
	logic [DATA_W-1:0] mem_q [2];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              do_wr, do_rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_rd)
				rd_ptr_q <= ~rd_ptr_q;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

@@ hdl/mbe_iter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_iter
// Escape-time iteration core: split-magnitude multipliers, product sum,
// escape test with shift and clamp, then the add of c.
// ----------------------------------------------------------------------------
module mbe_iter #(
	parameter int FRAC_BITS = 28
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	output logic                             q_pop,
	input  logic [2*(FRAC_BITS+4)-1:0]       q_data,
	input  logic [mbe_pkg::CNT_W-1:0]        max_iters,
	input  logic signed [31:0]               start_re,
	input  logic signed [31:0]               start_im,
	output mbe_pkg::mbe_cnt_t                done,
	input  logic                             done_ready
);
	localparam int W  = FRAC_BITS + 4;
	localparam int H  = (W + 1) / 2;
	localparam int PW = 2 * W;
	localparam int QW = 4 * H;
	localparam int SH_L = (FRAC_BITS >= mbe_pkg::START_FRAC) ?
		FRAC_BITS - mbe_pkg::START_FRAC : 0;
	localparam int SH_R = (FRAC_BITS >= mbe_pkg::START_FRAC) ?
		0 : mbe_pkg::START_FRAC - FRAC_BITS;

	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [PW:0] FOUR = {{(PW-2*FRAC_BITS-2){1'b0}}, 1'b1,
		{(2*FRAC_BITS+2){1'b0}}};

	function automatic logic [PW-1:0] pp_sum(input logic [2*H-1:0] ll,
		input logic [2*H-1:0] lh, input logic [2*H-1:0] hl,
		input logic [2*H-1:0] hh);
		logic [QW-1:0] t;
		t = {hh, ll} + ((QW'(lh) + QW'(hl)) << H);
		return t[PW-1:0];
	endfunction

	function automatic logic signed [W-1:0] shr_clamp(input logic signed [PW+1:0] v);
		logic signed [PW+1:0] s;
		s = v >>> FRAC_BITS;
		if ((&s[PW+1:W-1]) || !(|s[PW+1:W-1]))
			return s[W-1:0];
		return s[PW+1] ? WMIN : WMAX;
	endfunction

	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1])
			return s[W] ? WMIN : WMAX;
		return s[W-1:0];
	endfunction

	mbe_pkg::it_state_t it_q, it_nx;

	logic signed [W-1:0]      re_q, im_q, cre_q, cim_q;
	logic [mbe_pkg::CNT_W-1:0] cnt_q;
	logic [2*H-1:0]           rr_pp_s1 [4];
	logic [2*H-1:0]           ii_pp_s1 [4];
	logic [2*H-1:0]           ri_pp_s1 [4];
	logic                     sgn_s1;
	logic [PW-1:0]            rr_s2, ii_s2;
	logic signed [PW:0]       ri_s2;
	logic signed [W-1:0]      tre_s3, tim_s3;

	logic signed [W+31:0] sre_e, sim_e;
	logic signed [W-1:0]  sre_w, sim_w;
	logic [W-1:0]         mre, mim;
	logic [H-1:0]         re_lo, re_hi, im_lo, im_hi;
	logic [PW-1:0]        ri_p;
	logic [PW:0]          m2;
	logic                 esc;
	logic signed [PW+1:0] dr, di;

	always_comb begin
		sre_e = {{W{start_re[31]}}, start_re};
		sim_e = {{W{start_im[31]}}, start_im};
		sre_w = W'((sre_e <<< SH_L) >>> SH_R);
		sim_w = W'((sim_e <<< SH_L) >>> SH_R);
		mre   = re_q[W-1] ? W'(-re_q) : W'(re_q);
		mim   = im_q[W-1] ? W'(-im_q) : W'(im_q);
		re_lo = mre[H-1:0];
		re_hi = H'(mre[W-1:H]);
		im_lo = mim[H-1:0];
		im_hi = H'(mim[W-1:H]);
		ri_p  = pp_sum(ri_pp_s1[0], ri_pp_s1[1], ri_pp_s1[2], ri_pp_s1[3]);
		m2    = {1'b0, rr_s2} + {1'b0, ii_s2};
		esc   = m2 > FOUR;
		dr    = $signed({2'b00, rr_s2}) - $signed({2'b00, ii_s2});
		di    = {ri_s2, 1'b0};
	end

	always_comb begin
		it_nx = it_q;
		unique case (it_q)
			mbe_pkg::IT_IDLE: begin
				if (q_valid)
					it_nx = mbe_pkg::IT_MUL;
			end
			mbe_pkg::IT_MUL: begin
				if (cnt_q == max_iters)
					it_nx = mbe_pkg::IT_DONE;
				else
					it_nx = mbe_pkg::IT_SUM;
			end
			mbe_pkg::IT_SUM:  it_nx = mbe_pkg::IT_TEST;
			mbe_pkg::IT_TEST: it_nx = esc ? mbe_pkg::IT_DONE : mbe_pkg::IT_UPD;
			mbe_pkg::IT_UPD:  it_nx = mbe_pkg::IT_MUL;
			mbe_pkg::IT_DONE: begin
				if (done_ready)
					it_nx = mbe_pkg::IT_IDLE;
			end
			default: it_nx = mbe_pkg::IT_IDLE;
		endcase
	end

	always_comb begin
		q_pop      = (it_q == mbe_pkg::IT_IDLE) && q_valid;
		done.valid = (it_q == mbe_pkg::IT_DONE);
		done.count = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q  <= mbe_pkg::IT_IDLE;
			cnt_q <= '0;
		end else begin
			it_q <= it_nx;
			if (q_pop)
				cnt_q <= '0;
			else if (it_q == mbe_pkg::IT_UPD)
				cnt_q <= cnt_q + mbe_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (it_q)
			mbe_pkg::IT_IDLE: begin
				if (q_valid) begin
					cre_q <= q_data[2*W-1:W];
					cim_q <= q_data[W-1:0];
					re_q  <= sre_w;
					im_q  <= sim_w;
				end
			end
			mbe_pkg::IT_MUL: begin
				rr_pp_s1[0] <= re_lo * re_lo;
				rr_pp_s1[1] <= re_lo * re_hi;
				rr_pp_s1[2] <= re_hi * re_lo;
				rr_pp_s1[3] <= re_hi * re_hi;
				ii_pp_s1[0] <= im_lo * im_lo;
				ii_pp_s1[1] <= im_lo * im_hi;
				ii_pp_s1[2] <= im_hi * im_lo;
				ii_pp_s1[3] <= im_hi * im_hi;
				ri_pp_s1[0] <= re_lo * im_lo;
				ri_pp_s1[1] <= re_lo * im_hi;
				ri_pp_s1[2] <= re_hi * im_lo;
				ri_pp_s1[3] <= re_hi * im_hi;
				sgn_s1      <= re_q[W-1] ^ im_q[W-1];
			end
			mbe_pkg::IT_SUM: begin
				rr_s2 <= pp_sum(rr_pp_s1[0], rr_pp_s1[1], rr_pp_s1[2], rr_pp_s1[3]);
				ii_s2 <= pp_sum(ii_pp_s1[0], ii_pp_s1[1], ii_pp_s1[2], ii_pp_s1[3]);
				ri_s2 <= sgn_s1 ? -$signed({1'b0, ri_p}) : $signed({1'b0, ri_p});
			end
			mbe_pkg::IT_TEST: begin
				tre_s3 <= shr_clamp(dr);
				tim_s3 <= shr_clamp(di);
			end
			mbe_pkg::IT_UPD: begin
				re_q <= sat_add(tre_s3, cre_q);
				im_q <= sat_add(tim_s3, cim_q);
			end
			mbe_pkg::IT_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hdl/mbe_color.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_color
// Scales the count to three colour channels with bit-serial dividers and
// holds the finished result in the output register.
// ----------------------------------------------------------------------------
module mbe_color (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mbe_pkg::mbe_cnt_t         done,
	output logic                      done_ready,
	input  logic [mbe_pkg::CNT_W-1:0] max_iters,
	mbe_res_if.source                 res
);
	localparam int SW  = mbe_pkg::SCALE_W;
	localparam int CW  = mbe_pkg::CNT_W;
	localparam int STW = $clog2(SW);

	mbe_pkg::cl_state_t cl_q, cl_nx;
	logic [STW-1:0]     step_q;
	logic [SW-1:0]      div_q [3];
	logic [CW-1:0]      rem_q [3];
	logic [CW-1:0]      cnt_q;
	logic               zero_q;

	logic [SW-1:0] scale  [3];
	logic [SW-1:0] load   [3];
	logic [CW:0]   rem_sh [3];
	logic          ge     [3];

	always_comb begin
		scale[0] = SW'(mbe_pkg::RED_SCALE);
		scale[1] = SW'(mbe_pkg::GREEN_SCALE);
		scale[2] = SW'(mbe_pkg::BLUE_SCALE);
		for (int i = 0; i < 3; i++) begin
			load[i]   = SW'(done.count) * scale[i];
			rem_sh[i] = {rem_q[i], div_q[i][SW-1]};
			ge[i]     = rem_sh[i] >= {1'b0, max_iters};
		end
	end

	always_comb begin
		cl_nx = cl_q;
		unique case (cl_q)
			mbe_pkg::CL_IDLE: begin
				if (done.valid)
					cl_nx = mbe_pkg::CL_DIV;
			end
			mbe_pkg::CL_DIV: begin
				if (step_q == STW'(SW - 1))
					cl_nx = mbe_pkg::CL_FULL;
			end
			mbe_pkg::CL_FULL: begin
				if (res.ready)
					cl_nx = mbe_pkg::CL_IDLE;
			end
			default: cl_nx = mbe_pkg::CL_IDLE;
		endcase
	end

	always_comb begin
		done_ready     = (cl_q == mbe_pkg::CL_IDLE);
		res.valid      = (cl_q == mbe_pkg::CL_FULL);
		res.iter_count = cnt_q;
		// a zero limit gives black
		res.red        = zero_q ? '0 : div_q[0][6:0];
		res.green      = zero_q ? '0 : div_q[1][7:0];
		res.blue       = zero_q ? '0 : div_q[2][7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cl_q   <= mbe_pkg::CL_IDLE;
			step_q <= '0;
		end else begin
			cl_q <= cl_nx;
			if (cl_q == mbe_pkg::CL_DIV)
				step_q <= step_q + STW'(1);
			else
				step_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cl_q == mbe_pkg::CL_IDLE && done.valid) begin
			cnt_q  <= done.count;
			zero_q <= (max_iters == '0);
			for (int i = 0; i < 3; i++) begin
				div_q[i] <= load[i];
				rem_q[i] <= '0;
			end
		end else if (cl_q == mbe_pkg::CL_DIV) begin
			for (int i = 0; i < 3; i++) begin
				div_q[i] <= {div_q[i][SW-2:0], ge[i]};
				rem_q[i] <= ge[i] ? CW'(rem_sh[i] - {1'b0, max_iters}) : rem_sh[i][CW-1:0];
			end
		end
	end

endmodule

@@ hdl/mandelbrot_escape_time_pixel.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time pixel: coordinate mapping front, two-entry queue, iteration
// core and colour scaling with output register.
//
//   channel  dir  handshake            payload
//   pix      in   pix.valid/pix.ready  pixel_x, pixel_y
//   res      out  res.valid/res.ready  iter_count, red, green, blue
//   cfg      in   cfg_we               cfg_idx, cfg_data
//
// front: one quotient bit per cycle in each divider.
// core: each iteration steps through multiply, sum, test and update; the
//   limit stops it at the multiply step and an escape at the test step;
//   colour: load, bit-serial divide, then hold in the output register.
// the front keeps taking pixels while the core works, until the queue fills.
// a stalled result holds the colour stage, which then holds the core.
// reset clears control state; config registers return to their defaults.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel #(
	parameter int FRAC_BITS = 28,
	parameter int DIM_BITS  = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	mbe_pix_if.sink                            pix,
	mbe_res_if.source                          res,
	input  logic                               cfg_we,
	input  logic [mbe_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [mbe_pkg::CFG_DATA_W-1:0]     cfg_data
);
	localparam int W = FRAC_BITS + 4;

	logic [DIM_BITS:0]         width_q, height_q;
	logic [mbe_pkg::CNT_W-1:0] max_q;
	logic signed [31:0]        sre_q, sim_q;

	logic            push_valid, push_ready;
	logic [2*W-1:0]  push_data;
	logic            q_valid, q_pop;
	logic [2*W-1:0]  q_data;
	mbe_pkg::mbe_cnt_t done;
	logic            done_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= (DIM_BITS+1)'(mbe_pkg::RST_IMAGE_DIM);
			height_q <= (DIM_BITS+1)'(mbe_pkg::RST_IMAGE_DIM);
			max_q    <= mbe_pkg::RST_MAX_ITERS;
			sre_q    <= '0;
			sim_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				mbe_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data[DIM_BITS:0];
				mbe_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data[DIM_BITS:0];
				mbe_pkg::CFG_MAX_ITERS:    max_q    <= cfg_data[mbe_pkg::CNT_W-1:0];
				mbe_pkg::CFG_START_RE:     sre_q    <= cfg_data;
				mbe_pkg::CFG_START_IM:     sim_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mbe_front #(
		.FRAC_BITS(FRAC_BITS),
		.DIM_BITS (DIM_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.dim_w     (width_q),
		.dim_h     (height_q),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	mbe_fifo #(
		.DATA_W(2*W)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(push_valid),
		.wr_ready(push_ready),
		.wr_data (push_data),
		.rd_valid(q_valid),
		.rd_pop  (q_pop),
		.rd_data (q_data)
	);

	mbe_iter #(
		.FRAC_BITS(FRAC_BITS)
	) u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_data    (q_data),
		.max_iters (max_q),
		.start_re  (sre_q),
		.start_im  (sim_q),
		.done      (done),
		.done_ready(done_ready)
	);

	mbe_color u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.done      (done),
		.done_ready(done_ready),
		.max_iters (max_q),
		.res       (res)
	);

endmodule

@@ hdl/mbe_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks on the result channel of the escape-time pixel block.
// ----------------------------------------------------------------------------
module mbe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [9:0] iter_count,
	input logic [6:0] red,
	input logic [7:0] green,
	input logic [7:0] blue
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result request dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(iter_count) && $stable(red)
			&& $stable(green) && $stable(blue))
		else $error("result changed while stalled");

	a_color_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> red <= 7'd100 && green <= 8'd195 && blue <= 8'd220)
		else $error("colour channel above its scale");

	a_zero_black: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && iter_count == 10'd0 |-> red == 7'd0 && green == 8'd0
			&& blue == 8'd0)
		else $error("zero count gives a colour");

endmodule

bind mandelbrot_escape_time_pixel mbe_checker u_mbe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.iter_count(res.iter_count),
	.red       (res.red),
	.green     (res.green),
	.blue      (res.blue)
);
